### rtl/rotation_matrix_to_quaternion_top_macros.svh
// Assertion macros shared by the RTL of the quaternion converter.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checked only outside reset.
`define RMQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rmq assertion failed");
// Checked during reset as well.
`define RMQ_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("rmq reset assertion failed");
`else
`define RMQ_ASSERT(lbl, prop)
`define RMQ_ASSERT_RST(lbl, prop)
`endif
`endif

### rtl/rmq_pkg.sv
package rmq_pkg;

  // Number format of matrix elements and quaternion components.
  localparam int FRAC_BITS = 14;
  localparam int ONE = 1 << FRAC_BITS;

  // Square root: one result bit per stage.
  localparam int SQRT_STEPS = 16;
  // Quotient bits of each divider, enough to hold ONE.
  localparam int QBITS = FRAC_BITS + 1;

  // Stage map of the pipeline.
  localparam int ST_SQRT0 = 1;
  localparam int ST_ROUND = ST_SQRT0 + SQRT_STEPS;
  localparam int ST_PREP = ST_ROUND + 1;
  localparam int ST_SAT = ST_PREP + 1;
  localparam int ST_DIV0 = ST_SAT + 1;
  localparam int ST_LAST = ST_DIV0 + QBITS - 1;
  localparam int NST = ST_LAST + 1;

  // Which quaternion component is the pivot.
  typedef enum logic [1:0] {
    PIV_W = 2'd0,
    PIV_X = 2'd1,
    PIV_Y = 2'd2,
    PIV_Z = 2'd3
  } pivot_t;

  // Everything one matrix carries down the pipeline.
  typedef struct packed {
    pivot_t             sel;
    logic [31:0]        rad;
    logic [17:0]        srem;
    logic [15:0]        root;
    logic [16:0]        h;
    logic [16:0]        pivot;
    logic [17:0]        dv;
    logic [2:0]         neg;
    logic [2:0][16:0]   mag;
    logic [2:0][31:0]   drem;
    logic [2:0]         sat;
    logic [2:0][QBITS-1:0] q;
  } pipe_t;

endpackage

### rtl/rmq_sqrt_step.sv
module rmq_sqrt_step (
  input  logic [1:0]  rad_bits,
  input  logic [17:0] rem_in,
  input  logic [15:0] root_in,
  output logic [17:0] rem_out,
  output logic [15:0] root_out
);
  import rmq_pkg::*;

  logic [19:0] cur;
  logic [19:0] trial;

  // One restoring square-root step: bring down two radicand bits, try a one.
  always_comb begin
    cur = {rem_in, rad_bits};
    trial = {2'b00, root_in, 2'b01};
    if (cur >= trial) begin
      rem_out = 18'(cur - trial);
      root_out = {root_in[14:0], 1'b1};
    end else begin
      rem_out = cur[17:0];
      root_out = {root_in[14:0], 1'b0};
    end
  end

endmodule

### rtl/rmq_div_step.sv
module rmq_div_step (
  input  logic [31:0]            rem_in,
  input  logic [17:0]            dv,
  input  logic [3:0]             shamt,
  input  logic [rmq_pkg::QBITS-1:0] q_in,
  output logic [31:0]            rem_out,
  output logic [rmq_pkg::QBITS-1:0] q_out
);
  import rmq_pkg::*;

  logic [31:0] sh;

  // One restoring division step against the divisor shifted into place.
  always_comb begin
    sh = 32'(dv) << shamt;
    if (rem_in >= sh) begin
      rem_out = rem_in - sh;
      q_out = {q_in[QBITS-2:0], 1'b1};
    end else begin
      rem_out = rem_in;
      q_out = {q_in[QBITS-2:0], 1'b0};
    end
  end

endmodule

### rtl/rotation_matrix_to_quaternion_top.sv
// Channel | Direction | Handshake              | Payload
// mat     | in        | mat_valid / mat_stall  | r00 .. r22, signed Q1.14
// quat    | out       | quat_valid / quat_stall| quat_w .. quat_z, pivot_case
//
// One matrix is accepted per cycle while mat_stall is low.
// The pipeline runs the square root (one root bit per stage, 16 stages) followed
// by three parallel restoring dividers (one quotient bit per stage, 15 stages).
// Each stage advances when it is empty or the stage after it advances, so a
// stalled output only holds stages that are full. Reset clears all valid bits.
module rotation_matrix_to_quaternion_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               mat_valid,
  output logic               mat_stall,
  input  logic signed [15:0] r00,
  input  logic signed [15:0] r01,
  input  logic signed [15:0] r02,
  input  logic signed [15:0] r10,
  input  logic signed [15:0] r11,
  input  logic signed [15:0] r12,
  input  logic signed [15:0] r20,
  input  logic signed [15:0] r21,
  input  logic signed [15:0] r22,
  output logic               quat_valid,
  input  logic               quat_stall,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z,
  output logic [1:0]         pivot_case
);
  import rmq_pkg::*;

  `include "rotation_matrix_to_quaternion_top_macros.svh"

  pipe_t stg [NST];
  pipe_t nxt [NST];
  logic  vld [NST];
  logic  en  [NST+1];

  // Stage enables: a stage loads when it is empty or its successor loads.
  assign en[NST] = !quat_valid || !quat_stall;
  for (genvar g = 0; g < NST; g++) begin : g_en
    assign en[g] = !vld[g] || en[g+1];
  end
  assign mat_stall = !en[0];

  // Case selection, radicand and the three signed off-diagonal terms.
  always_comb begin
    logic signed [18:0] tr;
    logic signed [18:0] t;
    logic signed [17:0] d [3];
    logic signed [18:0] e00, e11, e22;
    e00 = 19'(r00);
    e11 = 19'(r11);
    e22 = 19'(r22);
    tr = e00 + e11 + e22;
    nxt[0] = '0;
    if (tr > 0) begin
      nxt[0].sel = PIV_W;
      t = 19'(ONE) + tr;
      d[0] = 18'(r21) - 18'(r12);
      d[1] = 18'(r02) - 18'(r20);
      d[2] = 18'(r10) - 18'(r01);
    end else if (r00 > r11 && r00 > r22) begin
      nxt[0].sel = PIV_X;
      t = 19'(ONE) + e00 - e11 - e22;
      d[0] = 18'(r21) - 18'(r12);
      d[1] = 18'(r01) + 18'(r10);
      d[2] = 18'(r02) + 18'(r20);
    end else if (r11 > r22) begin
      nxt[0].sel = PIV_Y;
      t = 19'(ONE) + e11 - e00 - e22;
      d[0] = 18'(r02) - 18'(r20);
      d[1] = 18'(r01) + 18'(r10);
      d[2] = 18'(r12) + 18'(r21);
    end else begin
      nxt[0].sel = PIV_Z;
      t = 19'(ONE) + e22 - e00 - e11;
      d[0] = 18'(r10) - 18'(r01);
      d[1] = 18'(r02) + 18'(r20);
      d[2] = 18'(r12) + 18'(r21);
    end
    if (t < 19'sd1) begin
      t = 19'sd1;
    end
    nxt[0].rad = 32'({t[16:0], 14'b0});
    for (int i = 0; i < 3; i++) begin
      nxt[0].neg[i] = d[i] < 0;
      nxt[0].mag[i] = d[i] < 0 ? 17'(-d[i]) : 17'(d[i]);
    end
  end

  // Per-stage work.
  for (genvar g = 1; g < NST; g++) begin : g_stage
    if (g < ST_ROUND) begin : g_sqrt
      logic [17:0] rem_o;
      logic [15:0] root_o;
      rmq_sqrt_step u_sqrt (
        .rad_bits (stg[g-1].rad[31:30]),
        .rem_in   (stg[g-1].srem),
        .root_in  (stg[g-1].root),
        .rem_out  (rem_o),
        .root_out (root_o)
      );
      always_comb begin
        nxt[g] = stg[g-1];
        nxt[g].rad = {stg[g-1].rad[29:0], 2'b00};
        nxt[g].srem = rem_o;
        nxt[g].root = root_o;
      end
    end else if (g == ST_ROUND) begin : g_round
      // Round the root to nearest.
      always_comb begin
        nxt[g] = stg[g-1];
        nxt[g].h = 17'(stg[g-1].root) +
                   17'(stg[g-1].srem > 18'(stg[g-1].root));
      end
    end else if (g == ST_PREP) begin : g_prep
      // Scaled dividends with the rounding offset, divisor 2h and the pivot.
      always_comb begin
        logic [17:0] hp1;
        nxt[g] = stg[g-1];
        hp1 = 18'(stg[g-1].h) + 18'd1;
        nxt[g].pivot = hp1[17:1];
        nxt[g].dv = {stg[g-1].h, 1'b0};
        for (int i = 0; i < 3; i++) begin
          nxt[g].drem[i] = 32'({stg[g-1].mag[i], 14'b0}) + 32'(stg[g-1].h);
        end
      end
    end else if (g == ST_SAT) begin : g_sat
      // A quotient above ONE saturates.
      always_comb begin
        logic [32:0] lim;
        nxt[g] = stg[g-1];
        lim = 33'(stg[g-1].dv) + 33'({stg[g-1].dv, 14'b0});
        for (int i = 0; i < 3; i++) begin
          nxt[g].sat[i] = {1'b0, stg[g-1].drem[i]} >= lim;
        end
      end
    end else begin : g_div
      logic [2:0][31:0]      rem_o;
      logic [2:0][QBITS-1:0] q_o;
      for (genvar k = 0; k < 3; k++) begin : g_lane
        rmq_div_step u_div (
          .rem_in  (stg[g-1].drem[k]),
          .dv      (stg[g-1].dv),
          .shamt   (4'(ST_LAST - g)),
          .q_in    (stg[g-1].q[k]),
          .rem_out (rem_o[k]),
          .q_out   (q_o[k])
        );
      end
      always_comb begin
        nxt[g] = stg[g-1];
        nxt[g].drem = rem_o;
        nxt[g].q = q_o;
      end
    end
  end

  // Pipeline registers with valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= mat_valid;
    end
    if (en[0]) begin
      stg[0] <= nxt[0];
    end
  end
  for (genvar g = 1; g < NST; g++) begin : g_reg
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en[g]) begin
        vld[g] <= vld[g-1];
      end
      if (en[g]) begin
        stg[g] <= nxt[g];
      end
    end
  end

  // Sign, saturation and placement of the components.
  logic signed [15:0] comp [3];
  logic signed [15:0] piv;
  logic signed [15:0] w_next, x_next, y_next, z_next;
  always_comb begin
    logic [15:0] m;
    for (int i = 0; i < 3; i++) begin
      m = stg[ST_LAST].sat[i] ? 16'(ONE) : 16'(stg[ST_LAST].q[i]);
      comp[i] = stg[ST_LAST].neg[i] ? -$signed(m) : $signed(m);
    end
    piv = (stg[ST_LAST].pivot > 17'(ONE)) ? 16'(ONE) : 16'(stg[ST_LAST].pivot);
    case (stg[ST_LAST].sel)
      PIV_W: begin
        w_next = piv;     x_next = comp[0]; y_next = comp[1]; z_next = comp[2];
      end
      PIV_X: begin
        w_next = comp[0]; x_next = piv;     y_next = comp[1]; z_next = comp[2];
      end
      PIV_Y: begin
        w_next = comp[0]; x_next = comp[1]; y_next = piv;     z_next = comp[2];
      end
      default: begin
        w_next = comp[0]; x_next = comp[1]; y_next = comp[2]; z_next = piv;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      quat_valid <= 1'b0;
    end else if (en[NST]) begin
      quat_valid <= vld[ST_LAST];
    end
    if (en[NST]) begin
      quat_w <= w_next;
      quat_x <= x_next;
      quat_y <= y_next;
      quat_z <= z_next;
      pivot_case <= stg[ST_LAST].sel;
    end
  end

  // When w is the pivot, it is always strictly positive.
  `RMQ_ASSERT(a_w_pivot_pos, quat_valid && pivot_case == PIV_W |-> quat_w > 16'sd0)
  // The x component stays within plus or minus one.
  `RMQ_ASSERT(a_x_range, quat_valid |-> quat_x <= 16'sd16384 && quat_x >= -16'sd16384)
  // Nothing leaves the block in the cycle after reset.
  `RMQ_ASSERT_RST(a_rst_empty, rst |=> !quat_valid)

endmodule
